@@ src/rwrl_pkg.sv @@
// Package for the reader/writer range lock table.
// Holds the request and response types and the command and outcome codes.
// No dependencies.
package rwrl_pkg;

   localparam logic [2:0] FUNC_RLOCK   = 3'd0;
   localparam logic [2:0] FUNC_WLOCK   = 3'd1;
   localparam logic [2:0] FUNC_RTRY    = 3'd2;
   localparam logic [2:0] FUNC_WTRY    = 3'd3;
   localparam logic [2:0] FUNC_RUNLOCK = 3'd4;
   localparam logic [2:0] FUNC_WUNLOCK = 3'd5;
   localparam logic [2:0] FUNC_DOWN    = 3'd6;
   localparam logic [2:0] FUNC_CANCEL  = 3'd7;

   localparam logic [1:0] OUT_DONE   = 2'd0;
   localparam logic [1:0] OUT_WAIT   = 2'd1;
   localparam logic [1:0] OUT_BUSY   = 2'd2;
   localparam logic [1:0] OUT_REJECT = 2'd3;

   localparam logic KIND_ACK  = 1'b0;
   localparam logic KIND_WAKE = 1'b1;

   localparam logic [4:0] HOLD_MAX = 5'd31;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  slot;
      logic [31:0] range_start;
      logic [31:0] range_last;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [3:0] target_slot;
      logic [1:0] outcome;
      logic [4:0] blockers;
      logic [4:0] write_holds;
      logic       last_of_run;
   } rsp_type;

endpackage

@@ src/reader_writer_range_lock_table_core.sv @@
// Reader/writer range lock table, top level.
// Uses rwrl_pkg for request/response types and codes.
//
// One request at a time: busy stays high from acceptance until the last
// response has been shown. A request rejected before the scan passes
// through ST_RDME, ST_DECIDE and ST_ACK. Unlock, downgrade and cancel pass
// through ST_RDME, ST_DECIDE, a scan of all entries and ST_ACK, then step
// through the slots in ST_WAKE from slot 0 up to the highest woken slot
// while wake notices go out. A lock request that reaches the scan adds
// ST_FIN after it, which writes the new entry unless the outcome is busy.
// The overlap scan runs through the entry memory one entry per cycle.
// Responses appear on rsp_data with rsp_valid high for a single cycle each
// and cannot be held off: the acknowledgement first, then wake notices in
// ascending slot order, last_of_run marking the final one.
module reader_writer_range_lock_table_core #(
   parameter int ENTRIES    = 16,
   parameter int RANGE_BITS = 32,
   parameter int ORDER_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rwrl_pkg::req_type req_data,
   output logic              rsp_valid,
   output rwrl_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RDME   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_FIN    = 3'd4;
   localparam logic [2:0] ST_ACK    = 3'd5;
   localparam logic [2:0] ST_WAKE   = 3'd6;

   typedef struct packed {
      logic [RANGE_BITS-1:0] start_pos;
      logic [RANGE_BITS-1:0] end_pos;
      logic                  is_reader;
      logic [ORDER_BITS-1:0] order;
      logic [4:0]            blockers;
   } entry_type;

   entry_type mem [ENTRIES];
   entry_type rd_q;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_en;
   entry_type        wr_data;

   logic [2:0]            state_ff, state_in;
   rwrl_pkg::req_type     req_ff;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [ENTRIES-1:0]    woke_ff, woke_in;
   logic [ORDER_BITS-1:0] arrival_ff, arrival_in;
   logic [4:0]            hold_ff, hold_in;
   logic [IDX_W:0]        scan_ff, scan_in;
   logic                  pv_ff, pv_in;
   logic [IDX_W-1:0]      pidx_ff, pidx_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [RANGE_BITS-1:0] rs_ff, rs_in, rl_ff, rl_in;
   logic                  me_rd_ff, me_rd_in;
   logic [ORDER_BITS-1:0] me_ord_ff, me_ord_in;
   logic [1:0]            outc_ff, outc_in;
   logic [4:0]            ackb_ff, ackb_in;
   logic [IDX_W-1:0]      widx_ff, widx_in;

   logic [IDX_W-1:0]      me;
   logic [RANGE_BITS-1:0] req_s, req_l;
   logic                  in_range, v, is_lock, lock_rd, ov, hit, later;
   logic [ORDER_BITS-1:0] odiff;
   logic [ENTRIES-1:0]    wbit;

   assign me      = IDX_W'(req_ff.slot);
   assign req_s   = RANGE_BITS'(req_ff.range_start);
   assign req_l   = RANGE_BITS'(req_ff.range_last);
   assign in_range = {28'd0, req_ff.slot} < 32'(ENTRIES);
   assign v       = in_range && valid_ff[me];
   assign is_lock = (req_ff.func == rwrl_pkg::FUNC_RLOCK) || (req_ff.func == rwrl_pkg::FUNC_WLOCK)
                 || (req_ff.func == rwrl_pkg::FUNC_RTRY) || (req_ff.func == rwrl_pkg::FUNC_WTRY);
   assign lock_rd = (req_ff.func == rwrl_pkg::FUNC_RLOCK) || (req_ff.func == rwrl_pkg::FUNC_RTRY);
   assign ov      = (rd_q.start_pos <= rl_ff) && (rs_ff <= rd_q.end_pos);
   assign odiff   = rd_q.order - me_ord_ff;
   assign later   = (odiff != '0) && !odiff[ORDER_BITS-1];
   assign wbit    = ENTRIES'(1) << widx_ff;

   // Filter for the entry under scan
   always_comb begin
      hit = 1'b0;
      if (pv_ff && pidx_ff != me && valid_ff[pidx_ff] && ov) begin
         unique case (req_ff.func)
            rwrl_pkg::FUNC_RUNLOCK: hit = !rd_q.is_reader;
            rwrl_pkg::FUNC_WUNLOCK: hit = 1'b1;
            rwrl_pkg::FUNC_DOWN:    hit = rd_q.is_reader;
            rwrl_pkg::FUNC_CANCEL:  hit = !(me_rd_ff && rd_q.is_reader) && later;
            default:                hit = !lock_rd || !rd_q.is_reader;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      woke_in    = woke_ff;
      arrival_in = arrival_ff;
      hold_in    = hold_ff;
      scan_in    = scan_ff;
      pv_in      = 1'b0;
      pidx_in    = pidx_ff;
      cnt_in     = cnt_ff;
      rs_in      = rs_ff;
      rl_in      = rl_ff;
      me_rd_in   = me_rd_ff;
      me_ord_in  = me_ord_ff;
      outc_in    = outc_ff;
      ackb_in    = ackb_ff;
      widx_in    = widx_ff;
      rd_addr    = me;
      wr_en      = 1'b0;
      wr_addr    = me;
      wr_data    = rd_q;
      rsp_valid  = 1'b0;
      rsp_data   = '0;
      rsp_data.write_holds = hold_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_RDME;
         end
         ST_RDME: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            woke_in  = '0;
            cnt_in   = '0;
            scan_in  = '0;
            outc_in  = rwrl_pkg::OUT_REJECT;
            ackb_in  = v ? rd_q.blockers : 5'd0;
            state_in = ST_ACK;
            me_rd_in  = rd_q.is_reader;
            me_ord_in = rd_q.order;
            rs_in     = rd_q.start_pos;
            rl_in     = rd_q.end_pos;
            if (is_lock) begin
               rs_in = req_s;
               rl_in = req_l;
               if (in_range && !v && req_s <= req_l) state_in = ST_SCAN;
            end else if (req_ff.func == rwrl_pkg::FUNC_CANCEL) begin
               if (v && rd_q.blockers != 5'd0) begin
                  valid_in[me] = 1'b0;
                  outc_in  = rwrl_pkg::OUT_DONE;
                  ackb_in  = 5'd0;
                  state_in = ST_SCAN;
               end
            end else if (v && rd_q.blockers == 5'd0 &&
                         rd_q.is_reader == (req_ff.func == rwrl_pkg::FUNC_RUNLOCK)) begin
               if (req_ff.func != rwrl_pkg::FUNC_DOWN) valid_in[me] = 1'b0;
               if (req_ff.func != rwrl_pkg::FUNC_RUNLOCK && hold_ff != 5'd0)
                  hold_in = hold_ff - 5'd1;
               if (req_ff.func == rwrl_pkg::FUNC_DOWN) begin
                  wr_en = 1'b1;
                  wr_data.is_reader = 1'b1;
               end
               outc_in  = rwrl_pkg::OUT_DONE;
               ackb_in  = 5'd0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue the next read while processing the previous entry
            rd_addr = scan_ff[IDX_W-1:0];
            if (scan_ff != (IDX_W+1)'(ENTRIES)) begin
               pv_in   = 1'b1;
               pidx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + (IDX_W+1)'(1);
            end
            if (hit) begin
               if (is_lock) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end else if (rd_q.blockers != 5'd0) begin
                  wr_en   = 1'b1;
                  wr_addr = pidx_ff;
                  wr_data.blockers = rd_q.blockers - 5'd1;
                  if (rd_q.blockers == 5'd1) begin
                     woke_in[pidx_ff] = 1'b1;
                     if (!rd_q.is_reader && hold_ff != rwrl_pkg::HOLD_MAX)
                        hold_in = hold_ff + 5'd1;
                  end
               end
            end
            if (!pv_ff && scan_ff == (IDX_W+1)'(ENTRIES))
               state_in = is_lock ? ST_FIN : ST_ACK;
         end
         ST_FIN: begin
            state_in = ST_ACK;
            if (!lock_rd && req_ff.func != rwrl_pkg::FUNC_WLOCK && cnt_ff != '0) begin
               outc_in = rwrl_pkg::OUT_BUSY;
               ackb_in = 5'd0;
            end else if (req_ff.func == rwrl_pkg::FUNC_RTRY && cnt_ff != '0) begin
               outc_in = rwrl_pkg::OUT_BUSY;
               ackb_in = 5'd0;
            end else begin
               wr_en             = 1'b1;
               wr_data.start_pos = rs_ff;
               wr_data.end_pos   = rl_ff;
               wr_data.is_reader = lock_rd;
               wr_data.order     = arrival_ff;
               wr_data.blockers  = 5'(cnt_ff);
               valid_in[me] = 1'b1;
               arrival_in   = arrival_ff + ORDER_BITS'(1);
               ackb_in      = 5'(cnt_ff);
               if (cnt_ff == '0) begin
                  outc_in = rwrl_pkg::OUT_DONE;
                  if (!lock_rd && hold_ff != rwrl_pkg::HOLD_MAX) hold_in = hold_ff + 5'd1;
               end else begin
                  outc_in = rwrl_pkg::OUT_WAIT;
               end
            end
         end
         ST_ACK: begin
            rsp_valid            = 1'b1;
            rsp_data.kind        = rwrl_pkg::KIND_ACK;
            rsp_data.target_slot = req_ff.slot;
            rsp_data.outcome     = outc_ff;
            rsp_data.blockers    = ackb_ff;
            rsp_data.last_of_run = (woke_ff == '0);
            widx_in  = '0;
            state_in = (woke_ff == '0) ? ST_IDLE : ST_WAKE;
         end
         ST_WAKE: begin
            widx_in = widx_ff + IDX_W'(1);
            if ((woke_ff & wbit) != '0) begin
               rsp_valid            = 1'b1;
               rsp_data.kind        = rwrl_pkg::KIND_WAKE;
               rsp_data.target_slot = 4'(widx_ff);
               rsp_data.outcome     = rwrl_pkg::OUT_DONE;
               rsp_data.last_of_run = ((woke_ff & ~wbit) == '0);
               woke_in = woke_ff & ~wbit;
               if ((woke_ff & ~wbit) == '0) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_q <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         woke_ff    <= '0;
         arrival_ff <= '0;
         hold_ff    <= '0;
         pv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         woke_ff    <= woke_in;
         arrival_ff <= arrival_in;
         hold_ff    <= hold_in;
         pv_ff      <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) req_ff <= req_data;
      scan_ff   <= scan_in;
      pidx_ff   <= pidx_in;
      cnt_ff    <= cnt_in;
      rs_ff     <= rs_in;
      rl_ff     <= rl_in;
      me_rd_ff  <= me_rd_in;
      me_ord_ff <= me_ord_in;
      outc_ff   <= outc_in;
      ackb_ff   <= ackb_in;
      widx_ff   <= widx_in;
   end

endmodule
